/* hw/rtl/vpfs_pkg.sv */
// shared types and constants of the voice prompt flash sequencer
`default_nettype none

package vpfs_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam logic [7:0] MAX_ID = 8'd254;
  localparam logic [7:0] NO_PROMPT = 8'hFF;
  localparam int INFO_BYTES = 8;
  localparam logic [23:0] ALL_ONES24 = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_BYTE    = 2'd2,
    CMD_DISMISS = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_REQ   = 3'd2,
    ACT_PCM   = 3'd3,
    ACT_END   = 3'd4
  } action_t;

  // one list operation, applied when a word finishes
  typedef struct packed {
    logic       add;
    logic       pop;
    logic       clear;
    logic [7:0] id;
  } list_op_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       zero_nxt;
    logic [7:0] rd_id;
  } list_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/voice_prompt_flash_sequencer.sv */
// top level: prompt playback sequencer with playlist, info parser and pcm pass-through
//
// input channel in_*: one word per command. in_tuser carries the command
// (add id, service step, flash byte arrives, dismiss playlist); in_tdata
// carries prompt id, flash byte and the sink ready flag.
// output channel out_*: exactly one word per input word. out_tuser is the
// action (none, start flash read, request byte, pcm byte out, end read);
// out_tdata carries flash address, pcm byte, all-done and overflow flags.
// each word is handled in order: first the playlist ram read is launched
// at the get index, then the command is applied and the output register
// loaded, once the registered read data of the playlist ram is ready.
// in_tready stays low from an accepted word until it has been applied.
// a result waiting in the output register does not block acceptance, but
// applying a command waits until the output register is free, so a
// stalled receiver holds the pipe after at most one word in flight.
// synchronous reset clears indices, address, length and phase; the
// playlist ram needs no clearing since only written entries are popped.
`default_nettype none

module voice_prompt_flash_sequencer
  import vpfs_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // prompt_id, flash_data, sink_ready, zero pad
  input  wire logic [1:0]  in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // flash_address, pcm_byte, all_done, list_overflow, pad
  output logic [2:0]       out_tuser   // action
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INFO_REQ,
    PH_INFO_WAIT,
    PH_INFO_END,
    PH_PCM_WAIT
  } phase_t;

  // positions inside the info block
  localparam logic [2:0] POS_ADDR_HI = 3'd1;
  localparam logic [2:0] POS_LEN_HI  = 3'd4;
  localparam logic [2:0] POS_LAST    = 3'(INFO_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [23:0] len_r, len_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic        busy_r;
  cmd_t        cmd_r;
  logic [7:0]  pid_r, fdata_r;
  logic        sready_r;

  logic        out_valid_r;
  action_t     out_act_r;
  logic [39:0] out_data_r;

  action_t     act;
  logic [23:0] fa;
  logic [7:0]  pcm, id;
  logic        ovf, done;

  logic        in_fire, step_en;
  list_op_t    op;
  list_stat_t  stat;

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign step_en   = busy_r && (!out_valid_r || out_tready);

  vpfs_list #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_list (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_fire),
    .op    (op),
    .stat  (stat)
  );

  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    act       = ACT_NONE;
    fa        = '0;
    pcm       = '0;
    ovf       = 1'b0;
    op        = '0;
    op.id     = pid_r;
    id        = stat.empty ? NO_PROMPT : stat.rd_id;
    unique case (cmd_r)
      CMD_ADD: begin
        op.add = step_en;
        ovf    = stat.full;
      end
      CMD_DISMISS: begin
        op.clear = step_en;
      end
      CMD_BYTE: begin
        if (phase_r == PH_INFO_WAIT) begin
          case (cnt_r)
            POS_ADDR_HI:      addr_nxt = {16'b0, fdata_r};
            3'd2, 3'd3:       addr_nxt = {addr_r[15:0], fdata_r};
            POS_LEN_HI:       len_nxt  = {16'b0, fdata_r};
            3'd5, 3'd6:       len_nxt  = {len_r[15:0], fdata_r};
            default:          ;
          endcase
          if (cnt_r == POS_LAST) begin
            if (addr_nxt == ALL_ONES24 || len_nxt == ALL_ONES24) begin
              addr_nxt = '0;
              len_nxt  = '0;
            end
            cnt_nxt   = '0;
            phase_nxt = PH_INFO_END;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            phase_nxt = PH_INFO_REQ;
          end
        end else if (phase_r == PH_PCM_WAIT) begin
          act = ACT_PCM;
          pcm = fdata_r;
          if (len_r != '0) begin
            len_nxt = len_r - 24'd1;
          end
          phase_nxt = PH_IDLE;
        end
      end
      CMD_SERVICE: begin
        unique case (phase_r)
          PH_IDLE: begin
            if (len_r == '0) begin
              op.pop = step_en;
              if (id <= MAX_ID) begin
                act       = ACT_START;
                fa        = {13'b0, id, 3'b000};
                cnt_nxt   = '0;
                phase_nxt = PH_INFO_REQ;
              end else if (addr_r != '0) begin
                act      = ACT_START;
                fa       = addr_r;
                addr_nxt = '0;
              end else begin
                act = ACT_END;
              end
            end else if (addr_r != '0) begin
              act      = ACT_START;
              fa       = addr_r;
              addr_nxt = '0;
            end else if (sready_r) begin
              act       = ACT_REQ;
              phase_nxt = PH_PCM_WAIT;
            end
          end
          PH_INFO_REQ: begin
            act       = ACT_REQ;
            phase_nxt = PH_INFO_WAIT;
          end
          PH_INFO_END: begin
            act       = ACT_END;
            phase_nxt = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    done = stat.zero_nxt && (len_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      addr_r      <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r   <= 1'b1;
        cmd_r    <= cmd_t'(in_tuser);
        pid_r    <= in_tdata[7:0];
        fdata_r  <= in_tdata[15:8];
        sready_r <= in_tdata[16];
      end
      if (step_en) begin
        busy_r      <= 1'b0;
        phase_r     <= phase_nxt;
        addr_r      <= addr_nxt;
        len_r       <= len_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
        out_act_r   <= act;
        out_data_r  <= {6'b0, ovf, done, pcm, fa};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/vpfs_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module vpfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/vpfs_list.sv */
// append-only playlist: put and get indices around the playlist ram
`default_nettype none

module vpfs_list
  import vpfs_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       rd_en,
  input  wire list_op_t   op,
  output list_stat_t      stat
);

  localparam int IW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(LIST_DEPTH);

  logic [IW-1:0] put_r, put_nxt;
  logic [IW-1:0] get_r, get_nxt;
  logic          empty, full, wr_en;
  logic [7:0]    rd_id;

  assign full  = put_r >= IW'(LIST_DEPTH);
  assign empty = (get_r == put_r) || (get_r >= IW'(LIST_DEPTH));
  assign wr_en = op.add && !full;

  always_comb begin
    put_nxt = put_r;
    get_nxt = get_r;
    if (op.clear) begin
      put_nxt = '0;
      get_nxt = '0;
    end else if (wr_en) begin
      put_nxt = put_r + 1'b1;
    end else if (op.pop) begin
      if (empty) begin
        put_nxt = '0;
        get_nxt = '0;
      end else begin
        get_nxt = get_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      put_r <= '0;
      get_r <= '0;
    end else begin
      put_r <= put_nxt;
      get_r <= get_nxt;
    end
  end

  // read is launched when a word is taken, data is ready the cycle after
  vpfs_ram #(
    .WIDTH (8),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (put_r[AW-1:0]),
    .wdata (op.id),
    .re    (rd_en),
    .raddr (get_r[AW-1:0]),
    .rdata (rd_id)
  );

  assign stat.empty    = empty;
  assign stat.full     = full;
  assign stat.zero_nxt = (put_nxt == '0) && (get_nxt == '0);
  assign stat.rd_id    = rd_id;

endmodule

`default_nettype wire

/* hw/rtl/vpfs_checker.sv */
// port-level checks of the sequencer, bound to the top level
`default_nettype none

module vpfs_port_checks
  import vpfs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // an accepted word keeps in_tready low until it has been applied
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on the cycle after an accept");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ACT_START) |-> (out_tdata[23:0] == 24'd0))
    else $error("flash address set without a start action");

  a_pcm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ACT_PCM) |-> (out_tdata[31:24] == 8'd0))
    else $error("pcm byte set without a pcm action");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33]) |-> (out_tuser == ACT_NONE))
    else $error("dropped add reported with an action");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output word changed");

endmodule

bind voice_prompt_flash_sequencer vpfs_port_checks u_vpfs_port_checks (.*);

`default_nettype wire

/* tb/vpfs_checker.sv */
// checker for the prompt sequencer: predicts every result word and compares it with the dut
module vpfs_checker
  import vpfs_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // prompt_id, flash_data, sink_ready, zero pad
  input  logic [1:0]  in_tuser,   // cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // flash_address, pcm_byte, all_done, list_overflow, pad
  input  logic [2:0]  out_tuser,  // action
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INFO_REQ,
    PH_INFO_WAIT,
    PH_INFO_END,
    PH_PCM_WAIT
  } play_phase_t;

  typedef struct packed {
    action_t     act;
    logic [23:0] addr;
    logic [7:0]  pcm;
    logic        done;
    logic        ovf;
  } play_word_t;

  logic [7:0]  playlist [LIST_DEPTH];
  int          put_idx;
  int          get_idx;
  logic [23:0] cur_addr;
  logic [23:0] len_left;
  play_phase_t phase;
  int          info_cnt;
  play_word_t  expected_words [$];
  int          reported;

  initial begin
    fail_count = 0;
    outstanding = 0;
    reported = 0;
  end

  // info block: id, address msb first, length msb first, checksum
  task automatic take_info_byte(input logic [7:0] b);
    int n;
    n = info_cnt;
    case (n)
      1: cur_addr = {16'd0, b};
      2, 3: cur_addr = {cur_addr[15:0], b};
      4: len_left = {16'd0, b};
      5, 6: len_left = {len_left[15:0], b};
      default: ;
    endcase
    n++;
    if (n >= INFO_BYTES) begin
      if (cur_addr == ALL_ONES24 || len_left == ALL_ONES24) begin
        cur_addr = '0;
        len_left = '0;
      end
      info_cnt = 0;
      phase = PH_INFO_END;
    end else begin
      info_cnt = n;
      phase = PH_INFO_REQ;
    end
  endtask

  task automatic service_step(input logic rdy, inout play_word_t w);
    logic [7:0] id;
    case (phase)
      PH_IDLE: begin
        if (len_left == 0) begin
          if (get_idx != put_idx && get_idx < LIST_DEPTH) begin
            id = playlist[get_idx];
            get_idx++;
          end else begin
            // pop from an empty list rewinds both indices
            id = NO_PROMPT;
            get_idx = 0;
            put_idx = 0;
          end
          if (id <= MAX_ID) begin
            w.act = ACT_START;
            w.addr = 24'(id) * 24'(INFO_BYTES);
            info_cnt = 0;
            phase = PH_INFO_REQ;
          end else if (cur_addr != 0) begin
            w.act = ACT_START;
            w.addr = cur_addr;
            cur_addr = '0;
          end else begin
            w.act = ACT_END;
          end
        end else if (cur_addr != 0) begin
          w.act = ACT_START;
          w.addr = cur_addr;
          cur_addr = '0;
        end else if (rdy) begin
          w.act = ACT_REQ;
          phase = PH_PCM_WAIT;
        end
      end
      PH_INFO_REQ: begin
        w.act = ACT_REQ;
        phase = PH_INFO_WAIT;
      end
      PH_INFO_END: begin
        w.act = ACT_END;
        phase = PH_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic predict_word(input cmd_t c, input logic [7:0] pid, input logic [7:0] fb,
                              input logic rdy, output play_word_t w);
    w = '{act: ACT_NONE, addr: '0, pcm: '0, done: 1'b0, ovf: 1'b0};
    case (c)
      CMD_ADD: begin
        if (put_idx < LIST_DEPTH) begin
          playlist[put_idx] = pid;
          put_idx++;
        end else begin
          w.ovf = 1'b1;
        end
      end
      CMD_DISMISS: begin
        get_idx = 0;
        put_idx = 0;
      end
      CMD_BYTE: begin
        if (phase == PH_INFO_WAIT) begin
          take_info_byte(fb);
        end else if (phase == PH_PCM_WAIT) begin
          w.act = ACT_PCM;
          w.pcm = fb;
          if (len_left != 0) len_left--;
          phase = PH_IDLE;
        end
      end
      default: service_step(rdy, w);
    endcase
    w.done = (get_idx == 0 && put_idx == 0 && len_left == 0);
  endtask

  always @(posedge clk) begin : watch_proc
    play_word_t got;
    play_word_t want;
    if (!rst_n) begin
      put_idx = 0;
      get_idx = 0;
      cur_addr = '0;
      len_left = '0;
      phase = PH_IDLE;
      info_cnt = 0;
      expected_words.delete();
    end else begin
      // compare before predicting: an output word never belongs to this cycle's input word
      if (out_tvalid && out_tready) begin
        got = '{act: action_t'(out_tuser), addr: out_tdata[23:0], pcm: out_tdata[31:24],
                done: out_tdata[32], ovf: out_tdata[33]};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (reported < 10)
            $display("%0t: result word with none expected: act %0d addr %h pcm %h done %b ovf %b",
                     $time, got.act, got.addr, got.pcm, got.done, got.ovf);
          reported++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reported < 10) begin
              $write("%0t: mismatch: expected act %0d addr %h pcm %h done %b ovf %b,",
                     $time, want.act, want.addr, want.pcm, want.done, want.ovf);
              $display(" got act %0d addr %h pcm %h done %b ovf %b",
                       got.act, got.addr, got.pcm, got.done, got.ovf);
            end
            reported++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_word(cmd_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], in_tdata[16], want);
        expected_words.push_back(want);
      end
    end
    outstanding = expected_words.size();
  end

endmodule

/* tb/tb_voice_prompt_flash_sequencer.sv */
// top of the sequencer testbench: clock, reset, command stimulus, watchdog and verdict
module tb_voice_prompt_flash_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import vpfs_pkg::*;

  localparam int TOTAL_WORDS    = 1374;
  localparam int CALM_TAIL      = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // prompt_id, flash_data, sink_ready, zero pad
  logic [1:0]  in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;  // flash_address, pcm_byte, all_done, list_overflow, pad
  logic [2:0]  out_tuser;  // action
  int          fail_count;
  int          outstanding;

  int          words_sent = 0;
  int          list_fill = 0;
  logic [7:0]  pending_ids [$];
  bit          strays_on = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  voice_prompt_flash_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  vpfs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // idle bursts everywhere except calm stretches and the tail of the run
  function automatic bit idling_allowed();
    return words_sent < TOTAL_WORDS - CALM_TAIL && (words_sent / 100) % 4 != 3;
  endfunction

  function automatic logic [7:0] random_id();
    return ($urandom_range(0, 11) == 0) ? NO_PROMPT : 8'($urandom_range(0, 254));
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (idling_allowed() && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(input cmd_t c, input logic [7:0] pid, input logic [7:0] fb,
                           input logic rdy);
    int gap;
    if (idling_allowed() && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = c;
    in_tdata = {7'd0, rdy, fb, pid};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic add_id(input logic [7:0] id);
    send_word(CMD_ADD, id, 8'($urandom), 1'($urandom));
    if (list_fill < LIST_DEPTH_DEF) begin
      pending_ids.push_back(id);
      list_fill++;
    end
  endtask

  task automatic dismiss_list();
    send_word(CMD_DISMISS, 8'($urandom), 8'($urandom), 1'($urandom));
    pending_ids.delete();
    list_fill = 0;
  endtask

  // a word that leaves playback untouched: list traffic, or a command the block ignores now
  task automatic stray_word(input bit awaiting);
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) add_id(8'($urandom));
    else if (sel == 1) dismiss_list();
    else if (awaiting) send_word(CMD_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom));
    else send_word(CMD_BYTE, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic maybe_stray(input bit awaiting);
    if (strays_on && $urandom_range(0, 11) == 0) stray_word(awaiting);
  endtask

  // one prompt from pop to last pcm byte; extreme uses an all-ones address in the info block
  task automatic play_next(input bit extreme);
    logic [7:0]  id;
    logic [23:0] addr;
    logic [23:0] len;
    logic [7:0]  info [8];
    bit          rdy;
    send_word(CMD_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom));
    if (pending_ids.size() > 0) begin
      id = pending_ids.pop_front();
    end else begin
      id = NO_PROMPT;
      list_fill = 0;
    end
    if (id > MAX_ID) return;
    if (extreme) begin
      addr = ALL_ONES24;
      len = 24'd2;
    end else begin
      case ($urandom_range(0, 11))
        0: addr = ALL_ONES24;
        1: addr = '0;
        default: addr = 24'($urandom_range(1, 24'hFFFFFE));
      endcase
      // a nonzero address with zero length would be skipped by the next pop
      if ($urandom_range(0, 15) == 0) len = ALL_ONES24;
      else if (addr == 0) len = 24'($urandom_range(0, 8));
      else if ($urandom_range(0, 9) == 0) len = 24'($urandom_range(20, 48));
      else len = 24'($urandom_range(1, 10));
    end
    info[0] = extreme ? 8'hFF : 8'($urandom);
    info[1] = addr[23:16];
    info[2] = addr[15:8];
    info[3] = addr[7:0];
    info[4] = len[23:16];
    info[5] = len[15:8];
    info[6] = len[7:0];
    info[7] = extreme ? 8'h00 : 8'($urandom);
    for (int k = 0; k < INFO_BYTES; k++) begin
      maybe_stray(1'b0);
      send_word(CMD_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom));
      maybe_stray(1'b1);
      send_word(CMD_BYTE, 8'($urandom), info[k], 1'($urandom));
    end
    maybe_stray(1'b0);
    send_word(CMD_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom));
    if (addr == ALL_ONES24 || len == ALL_ONES24) begin
      addr = '0;
      len = '0;
    end
    if (addr != 0) begin
      maybe_stray(1'b0);
      send_word(CMD_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    while (len != 0) begin
      rdy = ($urandom_range(0, 4) != 0);
      maybe_stray(1'b0);
      send_word(CMD_SERVICE, 8'($urandom), 8'($urandom), rdy);
      if (rdy) begin
        maybe_stray(1'b1);
        send_word(CMD_BYTE, 8'($urandom), 8'($urandom), 1'($urandom));
        len--;
      end
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_ADD;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: pop on empty list, ignored byte, dismiss, no-prompt id, all-ones info address
    play_next(1'b0);
    send_word(CMD_BYTE, 8'h00, 8'hFF, 1'b1);
    dismiss_list();
    add_id(NO_PROMPT);
    play_next(1'b0);
    add_id(MAX_ID);
    play_next(1'b1);

    strays_on = 1'b1;
    while (words_sent < TOTAL_WORDS) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 3)) add_id(random_id());
        while (pending_ids.size() > 0) play_next(1'b0);
        if ($urandom_range(0, 4) == 0) play_next(1'b0);
      end else if (pick < 63) begin
        // fill past the end of the list
        repeat ($urandom_range(30, 36)) add_id(random_id());
        if ($urandom_range(0, 1) == 0) dismiss_list();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) stray_word(1'b0);
      end else begin
        play_next(1'b0);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/vpfs_pkg.sv
hw/rtl/vpfs_ram.sv
hw/rtl/vpfs_list.sv
hw/rtl/voice_prompt_flash_sequencer.sv
hw/rtl/vpfs_checker.sv
tb/vpfs_checker.sv
tb/tb_voice_prompt_flash_sequencer.sv
